/* hw/rtl/hcbp_pkg.sv */
// Shared types and constants for the Huffman code bit packer.
// Used by huffman_code_bit_packer; no dependencies.

package hcbp_pkg;

    localparam int BYTE_W            = 8;
    localparam int CODE_W            = 32;
    localparam int LEN_W             = 6;
    localparam int ACC_W             = 40;
    localparam int SYM_W             = 8;
    localparam int FUNC_W            = 2;
    localparam int KIND_W            = 2;
    localparam int DEF_MAX_CODE_LEN  = 32;
    localparam int DEF_ALPHABET_SIZE = 256;

    // Function codes of an input word; code 3 is ignored
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } t_func;

    // Kinds of an output word
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA    = 2'd0,
        KIND_PARTIAL = 2'd1,
        KIND_COUNT   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT,
        ST_FLUSH_DATA,
        ST_FLUSH_COUNT
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] byte_kind;
        logic              last;
    } t_out_item;

endpackage

/* hw/rtl/hcbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/huffman_code_bit_packer.sv */
// Huffman code bit packer: code table load, symbol encode, tail flush.
// Load writes one code table entry. Encode reads the code table RAM, appends the
// code, then releases whole bytes through the one-byte output register until at
// most eight bits stay pending. Flush sends two output words (partial, count).
// Output words leave at most one per cycle from a registered output stage.
// Synchronous active-low reset empties the accumulator; the code table is not reset.

module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN  = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int ALPHABET_SIZE = hcbp_pkg::DEF_ALPHABET_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hcbp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hcbp_pkg::t_out_item o_out_data
);

    localparam int ADDR_W    = ALPHABET_SIZE > 1 ? $clog2(ALPHABET_SIZE) : 1;
    localparam int ENTRY_W   = hcbp_pkg::LEN_W + hcbp_pkg::CODE_W;
    localparam int LEN_BOUND = MAX_CODE_LEN > hcbp_pkg::CODE_W ? hcbp_pkg::CODE_W
                                                                : MAX_CODE_LEN;
    localparam logic [hcbp_pkg::LEN_W-1:0] BOUND_LEN = hcbp_pkg::LEN_W'(LEN_BOUND);
    localparam logic [hcbp_pkg::LEN_W-1:0] BYTE_LEN  = hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W);

    hcbp_pkg::t_state r_state, n_state;

    logic [hcbp_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [hcbp_pkg::LEN_W-1:0] r_pend, n_pend;
    logic                       r_sym_ok, n_sym_ok;
    logic                       r_out_valid, n_out_valid;
    hcbp_pkg::t_out_item        r_out_data, n_out_data;

    logic                       in_accept;
    logic                       sym_in_range;
    logic                       out_free;
    logic [hcbp_pkg::LEN_W-1:0] load_len;
    logic [hcbp_pkg::CODE_W:0]  load_mask;
    logic                       ram_wr_en;
    logic                       ram_rd_en;
    logic [ENTRY_W-1:0]         ram_wr_data;
    logic [ENTRY_W-1:0]         ram_rd_data;
    logic [hcbp_pkg::LEN_W-1:0] rd_len;
    logic [hcbp_pkg::CODE_W:0]  rd_mask;
    logic [hcbp_pkg::CODE_W-1:0] rd_code;
    logic [hcbp_pkg::LEN_W-1:0] app_pend;
    logic [hcbp_pkg::LEN_W-1:0] emit_shift;
    logic [hcbp_pkg::ACC_W:0]   emit_mask;
    logic [hcbp_pkg::BYTE_W-1:0] emit_byte;
    logic [hcbp_pkg::LEN_W-1:0] flush_cnt;

    assign in_accept    = i_in_valid && o_in_ready;
    assign sym_in_range = {1'b0, i_in_data.symbol} < (hcbp_pkg::SYM_W + 1)'(ALPHABET_SIZE);
    assign out_free     = !r_out_valid || i_out_ready;

    // Saturate and trim a code on load
    assign load_len  = (i_in_data.code_len > BOUND_LEN) ? BOUND_LEN : i_in_data.code_len;
    assign load_mask = ((hcbp_pkg::CODE_W + 1)'(1) << load_len) - (hcbp_pkg::CODE_W + 1)'(1);
    assign ram_wr_data = {load_len, i_in_data.code_bits & load_mask[hcbp_pkg::CODE_W-1:0]};
    assign ram_wr_en   = in_accept && (i_in_data.func == hcbp_pkg::FUNC_LOAD) && sym_in_range;
    assign ram_rd_en   = in_accept && (i_in_data.func == hcbp_pkg::FUNC_ENCODE);

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_code_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (i_in_data.symbol[ADDR_W-1:0]),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (i_in_data.symbol[ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Decode the looked-up entry, clamping its length to the bound
    assign rd_len   = (ram_rd_data[ENTRY_W-1 -: hcbp_pkg::LEN_W] > BOUND_LEN) ? BOUND_LEN
                    : ram_rd_data[ENTRY_W-1 -: hcbp_pkg::LEN_W];
    assign rd_mask  = ((hcbp_pkg::CODE_W + 1)'(1) << rd_len) - (hcbp_pkg::CODE_W + 1)'(1);
    assign rd_code  = ram_rd_data[hcbp_pkg::CODE_W-1:0] & rd_mask[hcbp_pkg::CODE_W-1:0];
    assign app_pend = r_pend + rd_len;

    // Oldest byte above the kept bits
    assign emit_shift = r_pend - BYTE_LEN;
    assign emit_byte  = hcbp_pkg::BYTE_W'(r_acc >> emit_shift);
    assign emit_mask  = ((hcbp_pkg::ACC_W + 1)'(1) << emit_shift) - (hcbp_pkg::ACC_W + 1)'(1);
    assign flush_cnt  = (r_pend > BYTE_LEN) ? BYTE_LEN : r_pend;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hcbp_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.func == hcbp_pkg::FUNC_ENCODE) begin
                        n_state = hcbp_pkg::ST_LOOKUP;
                    end else if (i_in_data.func == hcbp_pkg::FUNC_FLUSH) begin
                        n_state = hcbp_pkg::ST_FLUSH_DATA;
                    end
                end
            end
            hcbp_pkg::ST_LOOKUP: begin
                if (r_sym_ok && (rd_len != '0) && (app_pend > BYTE_LEN)) begin
                    n_state = hcbp_pkg::ST_EMIT;
                end else begin
                    n_state = hcbp_pkg::ST_IDLE;
                end
            end
            hcbp_pkg::ST_EMIT: begin
                if (out_free && (emit_shift <= BYTE_LEN)) begin
                    n_state = hcbp_pkg::ST_IDLE;
                end
            end
            hcbp_pkg::ST_FLUSH_DATA: begin
                if (out_free) begin
                    n_state = hcbp_pkg::ST_FLUSH_COUNT;
                end
            end
            hcbp_pkg::ST_FLUSH_COUNT: begin
                if (out_free) begin
                    n_state = hcbp_pkg::ST_IDLE;
                end
            end
            default: n_state = hcbp_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output word per state
    always_comb begin
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_sym_ok    = r_sym_ok;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        o_in_ready  = 1'b0;
        unique case (r_state)
            hcbp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_sym_ok   = sym_in_range;
            end
            hcbp_pkg::ST_LOOKUP: begin
                // append the code word below the pending bits
                if (r_sym_ok && (rd_len != '0)) begin
                    n_acc  = (r_acc << rd_len) | hcbp_pkg::ACC_W'(rd_code);
                    n_pend = app_pend;
                end
            end
            hcbp_pkg::ST_EMIT: begin
                // release the oldest byte, drop it from the accumulator
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_data.out_byte  = emit_byte;
                    n_out_data.byte_kind = hcbp_pkg::KIND_DATA;
                    n_out_data.last      = (emit_shift <= BYTE_LEN);
                    n_pend               = emit_shift;
                    n_acc                = r_acc & emit_mask[hcbp_pkg::ACC_W-1:0];
                end
            end
            hcbp_pkg::ST_FLUSH_DATA: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_data.out_byte  = r_acc[hcbp_pkg::BYTE_W-1:0];
                    n_out_data.byte_kind = hcbp_pkg::KIND_PARTIAL;
                    n_out_data.last      = 1'b0;
                end
            end
            hcbp_pkg::ST_FLUSH_COUNT: begin
                // send the bit count, then clear the accumulator
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_data.out_byte  = hcbp_pkg::BYTE_W'(flush_cnt);
                    n_out_data.byte_kind = hcbp_pkg::KIND_COUNT;
                    n_out_data.last      = 1'b1;
                    n_acc                = '0;
                    n_pend               = '0;
                end
            end
            default: begin
                n_acc  = '0;
                n_pend = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcbp_pkg::ST_IDLE;
            r_acc       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sym_ok   <= n_sym_ok;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
